// ===== design/wfsc_pkg.sv =====
// Shared types, constants and microprogram for the wall-follow stepper controller.
package wfsc_pkg;

  localparam int PHASE_COUNT = 8;
  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] FIN_STEP = PC_W'(19);

  localparam logic signed [15:0] HALT_LIMIT = 16'sd65;
  localparam logic signed [15:0] BAND_32 = 16'sd60;
  localparam logic signed [15:0] BAND_29 = 16'sd55;
  localparam logic signed [15:0] BAND_26 = 16'sd50;
  localparam logic signed [15:0] BAND_23 = 16'sd45;

  localparam logic [5:0] PERIOD_RESET = 6'd20;

  localparam logic [7:0] LEFT_PAT [8] = '{8'hC0, 8'h80, 8'h90, 8'h10,
                                          8'h30, 8'h20, 8'h60, 8'h40};
  localparam logic [7:0] RIGHT_PAT [8] = '{8'h03, 8'h01, 8'h09, 8'h08,
                                           8'h0C, 8'h04, 8'h06, 8'h02};

  typedef enum logic [2:0] {
    REG_FILTER_DIVIDE,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_SIDE_TARGET
  } reg_idx_e;

  typedef enum logic [2:0] {ACC_NOP, ACC_LDX, ACC_SUB, ACC_ADD, ACC_LDP} acc_op_e;
  typedef enum logic [2:0] {CF_A1, CF_A2, CF_B0, CF_B1, CF_B2} coef_sel_e;
  typedef enum logic [1:0] {OP_D0, OP_D1, OP_W} opnd_sel_e;

  // one control word of the microprogram
  typedef struct packed {
    logic            skip_nf;  // jump to target when no filter update
    logic [PC_W-1:0] target;
    logic            mul_en;
    coef_sel_e       coef;
    opnd_sel_e       opnd;
    acc_op_e         acc;
    logic            wr_w;     // w <= acc[29:14]
    logic            wr_out;   // value <= acc[29:14], shift delay line
    logic            ch;       // 0 front, 1 side
    logic            fin;      // band / wheel update, load result
  } uword_t;

  function automatic uword_t uw(logic mul, coef_sel_e cf, opnd_sel_e op, acc_op_e ac,
                                logic wrw, logic wro, logic ch);
    uword_t w;
    w = '0;
    w.mul_en = mul;
    w.coef   = cf;
    w.opnd   = op;
    w.acc    = ac;
    w.wr_w   = wrw;
    w.wr_out = wro;
    w.ch     = ch;
    return w;
  endfunction

  // biquad program for one channel, step k of 0..8
  function automatic uword_t chan_step(logic [3:0] k, logic ch);
    uword_t w;
    w = '0;
    case (k)
      4'd0:    w = uw(1'b1, CF_A1, OP_D0, ACC_LDX, 1'b0, 1'b0, ch);
      4'd1:    w = uw(1'b1, CF_A2, OP_D1, ACC_SUB, 1'b0, 1'b0, ch);
      4'd2:    w = uw(1'b0, CF_A1, OP_D0, ACC_SUB, 1'b0, 1'b0, ch);
      4'd3:    w = uw(1'b0, CF_A1, OP_D0, ACC_NOP, 1'b1, 1'b0, ch);
      4'd4:    w = uw(1'b1, CF_B0, OP_W,  ACC_NOP, 1'b0, 1'b0, ch);
      4'd5:    w = uw(1'b1, CF_B1, OP_D0, ACC_LDP, 1'b0, 1'b0, ch);
      4'd6:    w = uw(1'b1, CF_B2, OP_D1, ACC_ADD, 1'b0, 1'b0, ch);
      4'd7:    w = uw(1'b0, CF_A1, OP_D0, ACC_ADD, 1'b0, 1'b0, ch);
      4'd8:    w = uw(1'b0, CF_A1, OP_D0, ACC_NOP, 1'b0, 1'b1, ch);
      default: w = '0;
    endcase
    return w;
  endfunction

  // program ROM: step 0 dispatch, 1..9 front, 10..18 side, 19 finish
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    if (pc == '0) begin
      w.skip_nf = 1'b1;
      w.target  = FIN_STEP;
    end else if (pc <= PC_W'(9)) begin
      w = chan_step(4'(pc - PC_W'(1)), 1'b0);
    end else if (pc <= PC_W'(18)) begin
      w = chan_step(4'(pc - PC_W'(10)), 1'b1);
    end else begin
      w.fin = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [2:0] next_phase(logic [2:0] p);
    logic [3:0] n;
    n = {1'b0, p} + 4'd1;
    return (n >= 4'(PHASE_COUNT)) ? 3'd0 : n[2:0];
  endfunction

endpackage

// ===== design/wfsc_seq.sv =====
// Microprogram sequencer: step counter, ROM fetch and conditional jump.
module wfsc_seq import wfsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,    // item accepted
  input  logic   upd_i,      // this item updates the filters
  input  logic   hold_i,     // result slot still full
  output logic   busy_o,
  output uword_t ctrl_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          word;

  assign word   = ucode(pc_q);
  assign ctrl_o = busy_q ? word : '0;
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (word.fin) begin
      if (!hold_i) busy_d = 1'b0;
    end else if (word.skip_nf && !upd_i) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

// ===== design/wall_follow_stepper_controller.sv =====
// Top level: wall-follow controller with biquad filters and half-step stepper drive.
//
// One input item is one control tick with a front and a side distance sample;
// every tick yields exactly one result item with the coil pattern, the halt
// flag and both filtered distances. A tick without a filter update runs only
// the dispatch and finish steps; a tick that updates the filters (every
// filter_divide ticks) also runs the microprogram that drives both biquads
// through one shared 16x16 multiplier and a 32-bit accumulator, nine steps
// per channel. No new item is taken while the sequencer is busy. The result
// sits in an output register, so the next item is taken while it waits; the
// finish step holds only when that register is still full. Configuration
// writes are taken at any time but are meant for idle periods.
module wall_follow_stepper_controller import wfsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] front_sample, [15:8] side_sample
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] coil_pattern, [8] halted,
                                      // [24:9] front_filtered, [40:25] side_filtered
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic        [7:0]  divide_q;
  logic signed [15:0] a1_q, a2_q, b0_q, b1_q, b2_q, target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divide_q <= 8'd10;
      a1_q     <= -16'sd25575;
      a2_q     <= 16'sd10508;
      b0_q     <= 16'sd329;
      b1_q     <= 16'sd658;
      b2_q     <= 16'sd329;
      target_q <= 16'sd46;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FILTER_DIVIDE: divide_q <= cfg_data_i[7:0];
        REG_COEF_A1:       a1_q     <= cfg_data_i;
        REG_COEF_A2:       a2_q     <= cfg_data_i;
        REG_COEF_B0:       b0_q     <= cfg_data_i;
        REG_COEF_B1:       b1_q     <= cfg_data_i;
        REG_COEF_B2:       b2_q     <= cfg_data_i;
        REG_SIDE_TARGET:   target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  logic   busy, out_full, accept, fire;
  logic   upd_q, upd_d;
  uword_t ctrl;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_full      = m_axis_tvalid && !m_axis_tready;
  assign fire          = ctrl.fin && !out_full;

  wfsc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .upd_i   (upd_q),
    .hold_i  (out_full),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  // filter tick divider, evaluated when the item is taken
  logic [7:0] ftc_q, ftc_d, ftc_inc;

  assign ftc_inc = ftc_q + 8'd1;
  assign upd_d   = (ftc_inc == divide_q);
  assign ftc_d   = upd_d ? 8'd0 : ftc_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftc_q <= '0;
      upd_q <= 1'b0;
    end else if (accept) begin
      ftc_q <= ftc_d;
      upd_q <= upd_d;
    end
  end

  // latched samples
  logic [7:0] front_in_q, side_in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_in_q <= s_axis_tdata[7:0];
      side_in_q  <= s_axis_tdata[15:8];
    end
  end

  // biquad datapath: shared multiplier, product register, accumulator
  logic signed [15:0] front_d0_q, front_d1_q, side_d0_q, side_d1_q;
  logic signed [15:0] front_val_q, side_val_q, w_q;
  logic signed [15:0] coef_mux, opnd_mux, d0_mux, d1_mux;
  logic signed [31:0] prod_q, prod_d, acc_q, acc_d;
  logic        [7:0]  x_mux;

  assign d0_mux = ctrl.ch ? side_d0_q : front_d0_q;
  assign d1_mux = ctrl.ch ? side_d1_q : front_d1_q;
  assign x_mux  = ctrl.ch ? side_in_q : front_in_q;

  always_comb begin
    case (ctrl.coef)
      CF_A1:   coef_mux = a1_q;
      CF_A2:   coef_mux = a2_q;
      CF_B0:   coef_mux = b0_q;
      CF_B1:   coef_mux = b1_q;
      CF_B2:   coef_mux = b2_q;
      default: coef_mux = a1_q;
    endcase
    case (ctrl.opnd)
      OP_D0:   opnd_mux = d0_mux;
      OP_D1:   opnd_mux = d1_mux;
      OP_W:    opnd_mux = w_q;
      default: opnd_mux = d0_mux;
    endcase
  end

  // 16x16 signed product is exact in 32 bits
  assign prod_d = 32'(coef_mux) * 32'(opnd_mux);

  always_comb begin
    case (ctrl.acc)
      ACC_LDX: acc_d = {10'd0, x_mux, 14'd0};
      ACC_SUB: acc_d = acc_q - prod_q;
      ACC_ADD: acc_d = acc_q + prod_q;
      ACC_LDP: acc_d = prod_q;
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_en) prod_q <= prod_d;
    acc_q <= acc_d;
    if (ctrl.wr_w) w_q <= acc_q[29:14];
  end

  // filter state: value and two-deep delay line per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_d0_q  <= '0;
      front_d1_q  <= '0;
      side_d0_q   <= '0;
      side_d1_q   <= '0;
      front_val_q <= '0;
      side_val_q  <= '0;
    end else if (ctrl.wr_out) begin
      if (ctrl.ch) begin
        side_val_q <= acc_q[29:14];
        side_d1_q  <= side_d0_q;
        side_d0_q  <= w_q;
      end else begin
        front_val_q <= acc_q[29:14];
        front_d1_q  <= front_d0_q;
        front_d0_q  <= w_q;
      end
    end
  end

  // bands, wheel timing and coil pattern, all in the finish step
  logic [5:0] lp_q, lp_d, band, rp;
  logic [7:0] lt_q, rt_q, lt_inc, rt_inc, lt_d, rt_d;
  logic [2:0] lph_q, rph_q, lph_d, rph_d;
  logic [7:0] coil_q, coil_d;
  logic       halt, step_l, step_r;

  assign halt = (front_val_q > HALT_LIMIT);

  always_comb begin
    if      (front_val_q > BAND_32) band = 6'd32;
    else if (front_val_q > BAND_29) band = 6'd29;
    else if (front_val_q > BAND_26) band = 6'd26;
    else if (front_val_q > BAND_23) band = 6'd23;
    else                            band = PERIOD_RESET;
  end

  assign lp_d = halt ? lp_q : band;

  always_comb begin
    if      (side_val_q > target_q) rp = lp_d - 6'd5;
    else if (side_val_q < target_q) rp = lp_d + 6'd2;
    else                            rp = lp_d;
  end

  // tick counts saturate at 255
  assign lt_inc = (lt_q == 8'hFF) ? lt_q : lt_q + 8'd1;
  assign rt_inc = (rt_q == 8'hFF) ? rt_q : rt_q + 8'd1;

  assign step_l = !halt && (lt_inc >= {2'b00, lp_d});
  assign step_r = !halt && (rt_inc >= {2'b00, rp});

  assign lt_d  = step_l ? 8'd0 : lt_inc;
  assign rt_d  = step_r ? 8'd0 : rt_inc;
  assign lph_d = step_l ? next_phase(lph_q) : lph_q;
  assign rph_d = step_r ? next_phase(rph_q) : rph_q;

  always_comb begin
    coil_d = coil_q;
    if (step_l) coil_d = {LEFT_PAT[lph_q][7:4], coil_d[3:0]};
    if (step_r) coil_d = {coil_d[7:4], RIGHT_PAT[rph_q][3:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q   <= PERIOD_RESET;
      lt_q   <= '0;
      rt_q   <= '0;
      lph_q  <= '0;
      rph_q  <= '0;
      coil_q <= '0;
    end else if (fire) begin
      lp_q   <= lp_d;
      lt_q   <= lt_d;
      rt_q   <= rt_d;
      lph_q  <= lph_d;
      rph_q  <= rph_d;
      coil_q <= coil_d;
    end
  end

  // result register
  logic        out_valid_q;
  logic [47:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_data_q <= {7'd0, side_val_q, front_val_q, halt, coil_d};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/wfsc_chk.sv =====
// Port-level checker for the wall-follow stepper controller, with its bind.
module wfsc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // coil pattern of the last delivered item
  logic [7:0] last_coil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_coil_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_coil_q <= m_axis_tdata[7:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after an item was taken");

  a_halt_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8] == ($signed(m_axis_tdata[24:9]) > 16'sd65))
    else $error("halt flag disagrees with filtered front value");

  a_halt_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[8] |-> m_axis_tdata[7:0] == last_coil_q)
    else $error("coils moved while halted");

endmodule

bind wall_follow_stepper_controller wfsc_chk u_wfsc_chk (.*);
